>>> src/gbe_pkg.sv
// Shared types and constants for the gap buffer editor.
`timescale 1ns / 1ps

package gbe_pkg;

   typedef enum logic [2:0] {
      FN_TYPE      = 3'd0,
      FN_DELETE    = 3'd1,
      FN_BACKSPACE = 3'd2,
      FN_LEFT      = 3'd3,
      FN_RIGHT     = 3'd4,
      FN_READ      = 3'd5,
      FN_QUERY     = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EDGE  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_MOVE  = 2'd2,
      ST_WALK  = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic issue;
      logic move;
      logic walk;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_move;
      logic go_walk;
      logic walk_done;
   } stat_type;

   localparam logic [7:0] NEWLINE = 8'h0A;
   localparam int OUT_W = 11;

endpackage

>>> src/gbe_ctrl.sv
// Sequencing state machine of the gap buffer editor.
`timescale 1ns / 1ps

module gbe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gbe_pkg::stat_type stat,
   output gbe_pkg::cmd_type  cmd
);

   gbe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbe_pkg::ST_IDLE: begin
            if (start) state_in = gbe_pkg::ST_ISSUE;
         end
         gbe_pkg::ST_ISSUE: begin
            if (stat.go_move)      state_in = gbe_pkg::ST_MOVE;
            else if (stat.go_walk) state_in = gbe_pkg::ST_WALK;
            else                   state_in = gbe_pkg::ST_IDLE;
         end
         gbe_pkg::ST_MOVE: begin
            state_in = gbe_pkg::ST_IDLE;
         end
         gbe_pkg::ST_WALK: begin
            if (stat.walk_done) state_in = gbe_pkg::ST_IDLE;
         end
         default: begin
            state_in = gbe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = (state_ff != gbe_pkg::ST_IDLE);
      cmd.capture = (state_ff == gbe_pkg::ST_IDLE) && start;
      cmd.issue   = (state_ff == gbe_pkg::ST_ISSUE);
      cmd.move    = (state_ff == gbe_pkg::ST_MOVE);
      cmd.walk    = (state_ff == gbe_pkg::ST_WALK);
   end

endmodule

>>> src/gbe_datapath.sv
// Text store, gap bounds, prefix walk counters and response registers.
`timescale 1ns / 1ps

module gbe_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gbe_pkg::cmd_type                   cmd,
   output gbe_pkg::stat_type                  stat,
   input  logic [2:0]                         req_func,
   input  logic [7:0]                         req_char_in,
   input  logic [9:0]                         req_position,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [7:0]                         rsp_char_out,
   output logic [$clog2(CAPACITY+1)-1:0]      cursor,
   output logic [$clog2(CAPACITY+1)-1:0]      length,
   output logic [$clog2(CAPACITY+2)-1:0]      row,
   output logic [$clog2(CAPACITY+2)-1:0]      column
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(CAPACITY + 2);
   localparam int LW = ((PW > 10) ? PW : 10) + 1;
   localparam logic [PW-1:0] CAP = PW'(CAPACITY);

   logic [7:0] text_store [CAPACITY];

   logic [2:0]  func_ff;
   logic [7:0]  char_ff;
   logic [9:0]  pos_ff;
   logic [7:0]  rd_data_ff;
   logic [PW-1:0] gs_ff, gs_in, ge_ff, ge_in, walk_ff, walk_in;
   logic [RW-1:0] row_ff, row_in, col_ff, col_in;
   logic          valid_ff, valid_in;
   gbe_pkg::status_type status_ff, status_in;
   logic [7:0]  char_out_ff, char_out_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   gbe_pkg::func_type func;
   logic [PW-1:0] gap_size, text_len;
   logic [LW-1:0] pos_x, phys_x;
   logic          left_ok, right_ok, read_ok;

   assign func     = gbe_pkg::func_type'(func_ff);
   assign gap_size = ge_ff - gs_ff;
   assign text_len = CAP - gap_size;
   assign pos_x    = LW'(pos_ff);
   assign read_ok  = pos_x < LW'(text_len);
   assign phys_x   = (pos_x < LW'(gs_ff)) ? pos_x : pos_x + LW'(gap_size);
   assign left_ok  = (gs_ff != '0);
   assign right_ok = (ge_ff != CAP);

   always_comb begin
      stat.go_move   = ((func == gbe_pkg::FN_LEFT)  && left_ok)  ||
                       ((func == gbe_pkg::FN_RIGHT) && right_ok) ||
                       ((func == gbe_pkg::FN_READ)  && read_ok);
      stat.go_walk   = (func == gbe_pkg::FN_QUERY) && left_ok;
      stat.walk_done = (walk_ff == gs_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) text_store[mem_waddr] <= mem_wdata;
      rd_data_ff <= text_store[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         char_ff <= req_char_in;
         pos_ff  <= req_position;
      end
      walk_ff     <= walk_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      status_ff   <= status_in;
      char_out_ff <= char_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff    <= '0;
         ge_ff    <= CAP;
         valid_ff <= 1'b0;
      end else begin
         gs_ff    <= gs_in;
         ge_ff    <= ge_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      gs_in       = gs_ff;
      ge_in       = ge_ff;
      walk_in     = walk_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      status_in   = status_ff;
      char_out_in = char_out_ff;
      valid_in    = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = gs_ff[AW-1:0];
      mem_wdata   = char_ff;
      mem_raddr   = walk_ff[AW-1:0];

      if (cmd.capture) begin
         row_in      = '0;
         col_in      = '0;
         status_in   = gbe_pkg::STAT_OK;
         char_out_in = '0;
      end

      if (cmd.issue) begin
         valid_in = !(stat.go_move || stat.go_walk);
         case (func)
            gbe_pkg::FN_TYPE: begin
               if (gs_ff == ge_ff) begin
                  status_in = gbe_pkg::STAT_FULL;
               end else begin
                  mem_we = 1'b1;
                  gs_in  = gs_ff + PW'(1);
               end
            end
            gbe_pkg::FN_DELETE: begin
               if (right_ok) ge_in = ge_ff + PW'(1);
               else          status_in = gbe_pkg::STAT_EDGE;
            end
            gbe_pkg::FN_BACKSPACE: begin
               if (left_ok) gs_in = gs_ff - PW'(1);
               else         status_in = gbe_pkg::STAT_EDGE;
            end
            gbe_pkg::FN_LEFT: begin
               mem_raddr = AW'(gs_ff - PW'(1));
               if (!left_ok) status_in = gbe_pkg::STAT_EDGE;
            end
            gbe_pkg::FN_RIGHT: begin
               mem_raddr = ge_ff[AW-1:0];
               if (!right_ok) status_in = gbe_pkg::STAT_EDGE;
            end
            gbe_pkg::FN_READ: begin
               mem_raddr = phys_x[AW-1:0];
               if (!read_ok) status_in = gbe_pkg::STAT_RANGE;
            end
            gbe_pkg::FN_QUERY: begin
               row_in    = RW'(1);
               col_in    = RW'(1);
               mem_raddr = '0;
               walk_in   = PW'(1);
            end
            default: begin
            end
         endcase
      end

      if (cmd.move) begin
         valid_in = 1'b1;
         case (func)
            gbe_pkg::FN_LEFT: begin
               mem_we    = 1'b1;
               mem_waddr = AW'(ge_ff - PW'(1));
               mem_wdata = rd_data_ff;
               gs_in     = gs_ff - PW'(1);
               ge_in     = ge_ff - PW'(1);
            end
            gbe_pkg::FN_RIGHT: begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff;
               gs_in     = gs_ff + PW'(1);
               ge_in     = ge_ff + PW'(1);
            end
            default: begin
               char_out_in = rd_data_ff;
            end
         endcase
      end

      // rd_data_ff holds the byte at walk_ff - 1
      if (cmd.walk) begin
         if (rd_data_ff == gbe_pkg::NEWLINE) begin
            row_in = row_ff + RW'(1);
            col_in = RW'(1);
         end else begin
            col_in = col_ff + RW'(1);
         end
         if (stat.walk_done) begin
            valid_in = 1'b1;
         end else begin
            walk_in = walk_ff + PW'(1);
         end
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_char_out = char_out_ff;
   assign cursor       = gs_ff;
   assign length       = text_len;
   assign row          = row_ff;
   assign column       = col_ff;

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gs_ff <= ge_ff)
      else $error("gap start passed gap end");

   a_gap_cap: assert property (@(posedge clock) disable iff (reset)
      ge_ff <= CAP)
      else $error("gap end beyond capacity");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !valid_ff)
      else $error("response strobe right after request capture");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (walk_ff <= gs_ff) && (walk_ff != '0))
      else $error("prefix walk index out of bounds");

endmodule

>>> src/gap_buffer_editor_top.sv
// Type, delete, backspace and refused requests strobe straight after the issue state;
// left, right and read pass through the move state; a position query walks the bytes
// before the cursor one at a time through the text store's read port.
// busy is low again when the strobe shows, so a new request can start in that cycle.
// Reset empties the text (cursor 0, gap spans the store); the store is not cleared.
// The receiver cannot stall: each response strobe is high for exactly one cycle.
`timescale 1ns / 1ps

module gap_buffer_editor_top #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_char_in,
   input  logic [9:0]  req_position,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_char_out,
   output logic [10:0] rsp_cursor_pos,
   output logic [10:0] rsp_text_length,
   output logic [10:0] rsp_row,
   output logic [10:0] rsp_column
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(CAPACITY + 2);
   localparam int XW = (RW > gbe_pkg::OUT_W) ? RW : gbe_pkg::OUT_W;

   gbe_pkg::cmd_type  cmd;
   gbe_pkg::stat_type stat;

   logic [PW-1:0] cursor, length;
   logic [RW-1:0] row, column;
   logic [XW-1:0] cursor_x, length_x, row_x, column_x;

   gbe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   gbe_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_func),
      .req_char_in  (req_char_in),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_char_out (rsp_char_out),
      .cursor       (cursor),
      .length       (length),
      .row          (row),
      .column       (column)
   );

   // outputs carry the low 11 bits
   assign cursor_x = XW'(cursor);
   assign length_x = XW'(length);
   assign row_x    = XW'(row);
   assign column_x = XW'(column);

   assign rsp_cursor_pos  = cursor_x[gbe_pkg::OUT_W-1:0];
   assign rsp_text_length = length_x[gbe_pkg::OUT_W-1:0];
   assign rsp_row         = row_x[gbe_pkg::OUT_W-1:0];
   assign rsp_column      = column_x[gbe_pkg::OUT_W-1:0];

endmodule
